FILE: hdl/afu_pkg.sv
// Shared constants, widths and mode codes of the activation function unit.
package afu_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 12;
	localparam int MODE_W         = 3;

	localparam int Q_FRAC = 24;
	localparam int T_W    = 29;
	localparam int P2_W   = 31;
	localparam int P3_W   = 35;
	localparam int P4_W   = 37;
	localparam int SUM_W  = 36;

	localparam int N_W    = 34;
	localparam int N_HALF = 17;
	localparam int M3_W   = 34;
	localparam int M3_SH  = 35;
	localparam int PP_W   = N_HALF + M3_W;
	localparam int Q3_W   = 33;
	localparam logic [M3_W-1:0] M3_RECIP = 34'd11453246123;

	localparam int D_W    = 34;
	localparam int Q_W    = 24;
	localparam int PROD_W = 49;

	localparam longint T_LIMIT = 64'sd134217728;

	localparam int LEAK_W = 19;
	localparam logic signed [LEAK_W-1:0] LEAK_Q24 = 19'sd167772;

	typedef enum logic [MODE_W-1:0] {
		MODE_SIGMOID       = 3'd0,
		MODE_RELU          = 3'd1,
		MODE_LEAKY         = 3'd2,
		MODE_STEP          = 3'd3,
		MODE_LINEAR        = 3'd4,
		MODE_SIGMOID_DERIV = 3'd5,
		MODE_RELU_DERIV    = 3'd6,
		MODE_LINEAR_DERIV  = 3'd7
	} afu_mode_t;

endpackage

FILE: hdl/afu_div.sv
// Pipelined restoring divider: one quotient bit per stage, 2^48 / den.
module afu_div #(
	parameter int SIDE_W = afu_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [afu_pkg::D_W-1:0]  den,
	input  logic [SIDE_W-1:0]        side_in,
	output logic                     out_valid,
	output logic [afu_pkg::Q_W-1:0]  quo,
	output logic [SIDE_W-1:0]        side_out
);
	import afu_pkg::*;

	localparam logic [D_W-1:0] REM_INIT = D_W'(64'd1 << Q_FRAC);

	logic             vld_s  [0:Q_W];
	logic [D_W-1:0]   rem_s  [0:Q_W];
	logic [D_W-1:0]   den_s  [0:Q_W];
	logic [Q_W-1:0]   quo_s  [0:Q_W];
	logic [SIDE_W-1:0] side_s [0:Q_W];

	logic [D_W-1:0]   rem_nx [0:Q_W-1];
	logic [Q_W-1:0]   quo_nx [0:Q_W-1];

	always_comb begin
		logic [D_W:0] dbl;
		logic [D_W:0] diff;
		logic         ge;
		for (int k = 0; k < Q_W; k++) begin
			dbl       = {rem_s[k], 1'b0};
			diff      = dbl - {1'b0, den_s[k]};
			ge        = !diff[D_W];
			rem_nx[k] = ge ? diff[D_W-1:0] : dbl[D_W-1:0];
			quo_nx[k] = {quo_s[k][Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= Q_W; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= REM_INIT;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int k = 1; k <= Q_W; k++) begin
				rem_s[k]  <= rem_nx[k-1];
				den_s[k]  <= den_s[k-1];
				quo_s[k]  <= quo_nx[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign quo       = quo_s[Q_W];
	assign side_out  = side_s[Q_W];

endmodule

FILE: hdl/activation_function_unit.sv
// Activation function unit: top level, polynomial pipeline and result select.
//
// One signed fixed-point sample enters on the x channel (x_valid, x_stall,
// x_value) and one result leaves on the y channel (y_valid, y_stall,
// y_value). The function is chosen by the mode register, written through
// cfg_valid / cfg_ready / cfg_data; cfg_ready is always high. Write the mode
// only while no item is in flight.
//
// Throughput: one item per cycle while y is not stalled. Seven stages
// evaluate the exp polynomial and its divisions by six and twenty-four,
// 25 stages load the denominator and form the 24 sigmoid quotient bits
// one bit per stage, one stage forms the derivative product and one is
// the output register.
//
// Reset clears every valid bit and sets the mode to sigmoid. When the
// receiver stalls a valid result, the whole pipeline holds and x_stall is
// raised in the same cycle; nothing is dropped or repeated.
module activation_function_unit #(
	parameter int DATA_WIDTH = afu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = afu_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [afu_pkg::MODE_W-1:0]     cfg_data,
	input  logic                           x_valid,
	output logic                           x_stall,
	input  logic signed [DATA_WIDTH-1:0]   x_value,
	output logic                           y_valid,
	input  logic                           y_stall,
	output logic signed [DATA_WIDTH-1:0]   y_value
);
	import afu_pkg::*;

	localparam int SH     = Q_FRAC - FRAC_BITS;
	localparam int TX_W   = (DATA_WIDTH + SH + 1 > T_W + 1) ? DATA_WIDTH + SH + 1 : T_W + 1;
	localparam int SIG_SH = Q_FRAC - FRAC_BITS;
	localparam int DER_SH = 2 * Q_FRAC - FRAC_BITS;

	localparam logic signed [TX_W-1:0]  T_HI = TX_W'(T_LIMIT);
	localparam logic signed [TX_W-1:0]  T_LO = -T_HI;
	localparam logic [PROD_W-1:0]       MAX_POS = PROD_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
	localparam logic [DATA_WIDTH-1:0]   ONE_SAT = (FRAC_BITS >= DATA_WIDTH - 1) ?
		DATA_WIDTH'(MAX_POS) : DATA_WIDTH'(64'd1 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0] Q24_ONE_S = SUM_W'(64'sd1 << Q_FRAC);
	localparam logic signed [SUM_W-1:0] Q24_TWO_S = SUM_W'(64'sd1 << (Q_FRAC + 1));
	localparam logic [Q_W:0]            Q24_ONE_U = (Q_W + 1)'(64'd1 << Q_FRAC);

	function automatic logic [Q3_W-1:0] div3_join(input logic [PP_W-1:0] hi,
		input logic [PP_W-1:0] lo);
		logic [N_W+M3_W-1:0] acc;
		acc = {hi, N_HALF'(0)} + (N_W + M3_W)'(lo);
		return acc[M3_SH+Q3_W-1:M3_SH];
	endfunction

	afu_mode_t mode_q;
	logic      en;

	// stage 1
	logic                          v_s1;
	logic signed [T_W-1:0]         t_s1;
	logic signed [DATA_WIDTH-1:0]  simple_s1;
	// stage 2
	logic                          v_s2;
	logic signed [T_W-1:0]         t_s2;
	logic [P2_W-1:0]               p2_s2;
	logic signed [DATA_WIDTH-1:0]  simple_s2;
	// stage 3
	logic                          v_s3;
	logic signed [T_W-1:0]         t_s3;
	logic [P2_W-1:0]               p2_s3;
	logic signed [P3_W-1:0]        p3_s3;
	logic signed [DATA_WIDTH-1:0]  simple_s3;
	// stage 4
	logic                          v_s4;
	logic signed [T_W-1:0]         t_s4;
	logic [P2_W-1:0]               p2_s4;
	logic                          p3neg_s4;
	logic [N_W-1:0]                n3_s4;
	logic [P4_W-1:0]               p4_s4;
	logic signed [DATA_WIDTH-1:0]  simple_s4;
	// stage 5
	logic                          v_s5;
	logic signed [T_W-1:0]         t_s5;
	logic [P2_W-1:0]               p2_s5;
	logic                          p3neg_s5;
	logic [PP_W-1:0]               pp3_lo_s5;
	logic [PP_W-1:0]               pp3_hi_s5;
	logic [PP_W-1:0]               pp4_lo_s5;
	logic [PP_W-1:0]               pp4_hi_s5;
	logic signed [DATA_WIDTH-1:0]  simple_s5;
	// stage 6
	logic                          v_s6;
	logic signed [T_W-1:0]         t_s6;
	logic [P2_W-1:0]               p2_s6;
	logic                          p3neg_s6;
	logic [Q3_W-1:0]               q3_s6;
	logic [Q3_W-1:0]               q4_s6;
	logic signed [DATA_WIDTH-1:0]  simple_s6;
	// stage 7
	logic                          v_s7;
	logic signed [SUM_W-1:0]       a_s7;
	logic signed [SUM_W-1:0]       b_s7;
	logic signed [DATA_WIDTH-1:0]  simple_s7;
	// divider output and stage 33
	logic                          v_div;
	logic [Q_W-1:0]                s_div;
	logic [DATA_WIDTH-1:0]         simple_div;
	logic                          v_s33;
	logic [Q_W-1:0]                s_s33;
	logic [PROD_W-1:0]             prod_s33;
	logic signed [DATA_WIDTH-1:0]  simple_s33;
	// output register
	logic                          y_valid_q;
	logic signed [DATA_WIDTH-1:0]  y_value_q;

	logic signed [TX_W-1:0]                x_ext;
	logic signed [TX_W-1:0]                t_wide;
	logic signed [T_W-1:0]                 t_c;
	logic                                  x_pos;
	logic signed [DATA_WIDTH+LEAK_W-1:0]   leak_prod;
	logic signed [DATA_WIDTH-1:0]          leak_c;
	logic signed [DATA_WIDTH-1:0]          simple_c;
	logic signed [2*T_W-1:0]               sq_c;
	logic signed [P2_W+T_W:0]              cube_c;
	logic signed [P3_W+T_W-1:0]            quart_c;
	logic signed [P3_W-1:0]                p3_mag;
	logic [N_W-1:0]                        n4_c;
	logic signed [SUM_W-1:0]               a_c;
	logic signed [SUM_W-1:0]               b_c;
	logic signed [SUM_W-1:0]               d_sum;
	logic [Q_W:0]                          comp_c;
	logic [PROD_W-1:0]                     sig_w;
	logic [PROD_W-1:0]                     der_w;
	logic signed [DATA_WIDTH-1:0]          y_c;

	assign en        = !(y_valid_q && y_stall);
	assign x_stall   = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SIGMOID;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= afu_mode_t'(cfg_data);
		end
	end

	// input stage: simple functions and clamped t = -x
	always_comb begin
		x_ext     = TX_W'(x_value);
		t_wide    = (-x_ext) <<< SH;
		x_pos     = !x_value[DATA_WIDTH-1] && (x_value != '0);
		leak_prod = (DATA_WIDTH + LEAK_W)'(x_value) * (DATA_WIDTH + LEAK_W)'(LEAK_Q24);
		leak_c    = DATA_WIDTH'(leak_prod >>> Q_FRAC);
		if (t_wide > T_HI) begin
			t_c = T_W'(T_HI);
		end else if (t_wide < T_LO) begin
			t_c = T_W'(T_LO);
		end else begin
			t_c = T_W'(t_wide);
		end
		case (mode_q)
			MODE_RELU: begin
				simple_c = x_pos ? x_value : '0;
			end
			MODE_LEAKY: begin
				simple_c = x_pos ? x_value : leak_c;
			end
			MODE_STEP, MODE_RELU_DERIV: begin
				simple_c = x_pos ? ONE_SAT : '0;
			end
			MODE_LINEAR: begin
				simple_c = x_value;
			end
			MODE_LINEAR_DERIV: begin
				simple_c = ONE_SAT;
			end
			default: begin
				simple_c = '0;
			end
		endcase
	end

	always_comb begin
		sq_c    = (2 * T_W)'(t_s1) * (2 * T_W)'(t_s1);
		cube_c  = (P2_W + T_W + 1)'($signed({1'b0, p2_s2})) * (P2_W + T_W + 1)'(t_s2);
		quart_c = (P3_W + T_W)'(p3_s3) * (P3_W + T_W)'(t_s3);
		p3_mag  = p3_s3[P3_W-1] ? -p3_s3 : p3_s3;
		n4_c    = p4_s4[P4_W-1:3];
		a_c     = Q24_TWO_S + SUM_W'(t_s6) + SUM_W'(p2_s6 >> 1);
		b_c     = SUM_W'(q4_s6) + (p3neg_s6 ? -SUM_W'(q3_s6) : SUM_W'(q3_s6));
		d_sum   = a_s7 + b_s7;
		comp_c  = Q24_ONE_U - {1'b0, s_div};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s33     <= 1'b0;
			y_valid_q <= 1'b0;
		end else if (en) begin
			v_s1      <= x_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s33     <= v_div;
			y_valid_q <= v_s33;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1      <= t_c;
			simple_s1 <= simple_c;

			t_s2      <= t_s1;
			p2_s2     <= sq_c[Q_FRAC+P2_W-1:Q_FRAC];
			simple_s2 <= simple_s1;

			t_s3      <= t_s2;
			p2_s3     <= p2_s2;
			p3_s3     <= cube_c[Q_FRAC+P3_W-1:Q_FRAC];
			simple_s3 <= simple_s2;

			t_s4      <= t_s3;
			p2_s4     <= p2_s3;
			p3neg_s4  <= p3_s3[P3_W-1];
			n3_s4     <= p3_mag[N_W:1];
			p4_s4     <= quart_c[Q_FRAC+P4_W-1:Q_FRAC];
			simple_s4 <= simple_s3;

			t_s5      <= t_s4;
			p2_s5     <= p2_s4;
			p3neg_s5  <= p3neg_s4;
			pp3_lo_s5 <= PP_W'(n3_s4[N_HALF-1:0]) * PP_W'(M3_RECIP);
			pp3_hi_s5 <= PP_W'(n3_s4[N_W-1:N_HALF]) * PP_W'(M3_RECIP);
			pp4_lo_s5 <= PP_W'(n4_c[N_HALF-1:0]) * PP_W'(M3_RECIP);
			pp4_hi_s5 <= PP_W'(n4_c[N_W-1:N_HALF]) * PP_W'(M3_RECIP);
			simple_s5 <= simple_s4;

			t_s6      <= t_s5;
			p2_s6     <= p2_s5;
			p3neg_s6  <= p3neg_s5;
			q3_s6     <= div3_join(pp3_hi_s5, pp3_lo_s5);
			q4_s6     <= div3_join(pp4_hi_s5, pp4_lo_s5);
			simple_s6 <= simple_s5;

			a_s7      <= a_c;
			b_s7      <= b_c;
			simple_s7 <= simple_s6;

			s_s33      <= s_div;
			prod_s33   <= PROD_W'(s_div) * PROD_W'(comp_c);
			simple_s33 <= simple_div;

			y_value_q <= y_c;
		end
	end

	afu_div #(
		.SIDE_W(DATA_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s7),
		.den      (d_sum[D_W-1:0]),
		.side_in  (simple_s7),
		.out_valid(v_div),
		.quo      (s_div),
		.side_out (simple_div)
	);

	// result select and saturation
	always_comb begin
		sig_w = PROD_W'(s_s33) >> SIG_SH;
		der_w = prod_s33 >> DER_SH;
		case (mode_q)
			MODE_SIGMOID: begin
				y_c = (sig_w > MAX_POS) ? DATA_WIDTH'(MAX_POS) : DATA_WIDTH'(sig_w);
			end
			MODE_SIGMOID_DERIV: begin
				y_c = (der_w > MAX_POS) ? DATA_WIDTH'(MAX_POS) : DATA_WIDTH'(der_w);
			end
			default: begin
				y_c = simple_s33;
			end
		endcase
	end

	assign y_valid = y_valid_q;
	assign y_value = y_value_q;

	a_den_above_one: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (d_sum > Q24_ONE_S))
		else $error("sigmoid denominator not above one");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(x_valid && !x_stall) |=> v_s1)
		else $error("accepted item missing from first stage");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!y_valid |-> !x_stall)
		else $error("input stalled with empty output register");

	a_deriv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s33 |-> (prod_s33 <= (PROD_W'(1) << (2 * Q_FRAC - 2))))
		else $error("sigmoid derivative product out of range");

endmodule

FILE: test/tb.sv
// Testbench for the activation function unit: predicts every result per mode and checks it.
`timescale 1ns / 100ps

module tb;
	import afu_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint Q24_ONE = 64'sd1 <<< Q_FRAC;
	localparam longint T_MAX = 64'sd8 <<< Q_FRAC;
	localparam longint LEAK_SLOPE = 64'sd167772;
	localparam longint UNIT = 64'sd1 <<< FB;
	localparam longint Y_MAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint Y_MIN = -Y_MAX - 1;
	localparam int HOLDOFF_LEN = 150;
	localparam int LATENCY = 33;

	typedef logic signed [DW-1:0] sample_t;

	typedef struct {
		sample_t x;
		afu_mode_t mode;
		sample_t y;
	} result_rec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [MODE_W-1:0] cfg_data;
	logic x_valid;
	logic x_stall;
	sample_t x_value;
	logic y_valid;
	logic y_stall;
	sample_t y_value;

	result_rec_t y_expected_q[$];
	result_rec_t head_rec;
	afu_mode_t mode_now = MODE_SIGMOID;
	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit holdoff_req = 1'b0;
	int holdoff_left = 0;

	activation_function_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.x_valid(x_valid),
		.x_stall(x_stall),
		.x_value(x_value),
		.y_valid(y_valid),
		.y_stall(y_stall),
		.y_value(y_value)
	);

	always #6 clk = ~clk;

	function automatic longint sigmoid_q24(longint xv);
		longint t, p2, p3, p4, e, d;
		t = -xv * (64'sd1 <<< (Q_FRAC - FB));
		if (t > T_MAX)
			t = T_MAX;
		if (t < -T_MAX)
			t = -T_MAX;
		p2 = (t * t) >>> Q_FRAC;
		p3 = (p2 * t) >>> Q_FRAC;
		p4 = (p3 * t) >>> Q_FRAC;
		e = Q24_ONE + t + p2 / 2 + p3 / 6 + p4 / 24;
		d = Q24_ONE + e;
		if (d <= 0)
			return 64'sh7fff_ffff_ffff_ffff >>> 16;
		return (64'sd1 <<< 48) / d;
	endfunction

	function automatic sample_t activate(afu_mode_t m, sample_t x);
		longint xv, y, s;
		xv = x;
		case (m)
			MODE_SIGMOID: y = sigmoid_q24(xv) >>> (Q_FRAC - FB);
			MODE_RELU: y = (xv > 0) ? xv : 64'sd0;
			MODE_LEAKY: y = (xv > 0) ? xv : ((xv * LEAK_SLOPE) >>> Q_FRAC);
			MODE_STEP, MODE_RELU_DERIV: y = (xv > 0) ? UNIT : 64'sd0;
			MODE_LINEAR: y = xv;
			MODE_SIGMOID_DERIV: begin
				s = sigmoid_q24(xv);
				y = ((s * (Q24_ONE - s)) >>> Q_FRAC) >>> (Q_FRAC - FB);
			end
			default: y = UNIT;
		endcase
		if (y > Y_MAX)
			y = Y_MAX;
		else if (y < Y_MIN)
			y = Y_MIN;
		return sample_t'(y);
	endfunction

	function automatic sample_t rand_sample();
		int pick;
		sample_t edges[4];
		edges = '{sample_t'(Y_MIN), sample_t'(Y_MAX), sample_t'(0), sample_t'(-1)};
		pick = $urandom_range(9);
		if (pick < 5)
			return sample_t'($urandom);
		if (pick < 9)
			return sample_t'(int'($urandom_range(12288)) - 6144);
		return edges[$urandom_range(3)];
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic send_sample(input sample_t v);
		result_rec_t rec;
		if ($urandom_range(99) < idle_pct) begin
			x_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		x_valid <= 1'b1;
		x_value <= v;
		do @(posedge clk); while (x_stall);
		rec.x = v;
		rec.mode = mode_now;
		rec.y = activate(mode_now, v);
		y_expected_q.push_back(rec);
	endtask

	task automatic wait_drain();
		x_valid <= 1'b0;
		do @(posedge clk); while (y_expected_q.size() != 0);
	endtask

	task automatic set_mode(input afu_mode_t m);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_now = m;
	endtask

	task automatic test_directed();
		int pts[$];
		idle_pct = 0;
		stall_pct = 0;
		pts = '{-32768, 32767, 0, 1, -1, 4096, -4096};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_RELU);
		pts = '{-1, 0, 1, 32767};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_LEAKY);
		pts = '{-32768, -1, -100, 32767};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_STEP);
		pts = '{0, 1};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_LINEAR);
		pts = '{-32768, 32767};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_SIGMOID_DERIV);
		pts = '{0, -32768, 32767};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_RELU_DERIV);
		pts = '{0, 1};
		foreach (pts[i]) send_sample(sample_t'(pts[i]));
		set_mode(MODE_LINEAR_DERIV);
		send_sample(sample_t'(-5));
	endtask

	task automatic test_modes_under_idling();
		int idle_tab[4];
		int stall_tab[4];
		afu_mode_t m;
		idle_tab = '{0, 65, 0, 14};
		stall_tab = '{0, 0, 65, 14};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			m = m.first();
			do begin
				set_mode(m);
				repeat (16) send_sample(rand_sample());
				m = m.next();
			end while (m != m.first());
		end
	endtask

	task automatic test_output_holdoff();
		set_mode(MODE_LEAKY);
		idle_pct = 0;
		stall_pct = 0;
		holdoff_req = 1'b1;
		repeat (80) send_sample(rand_sample());
	endtask

	task automatic test_pause_until_drained();
		set_mode(MODE_SIGMOID_DERIV);
		idle_pct = 14;
		stall_pct = 14;
		repeat (12) send_sample(rand_sample());
		wait_drain();
		repeat (12) send_sample(rand_sample());
	endtask

	// hold the output for a counted stretch on request, else stall at random
	always @(posedge clk) begin
		if (holdoff_req) begin
			holdoff_left = HOLDOFF_LEN;
			holdoff_req = 1'b0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			y_stall <= 1'b1;
		end else begin
			y_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && y_valid && !y_stall) begin
			if (y_expected_q.size() == 0) begin
				report_mismatch($sformatf("y_value %0d with no item pending", y_value));
			end else begin
				head_rec = y_expected_q.pop_front();
				if (y_value !== head_rec.y)
					report_mismatch($sformatf("%s x=%0d: y_value %0d, want %0d",
						head_rec.mode.name(), head_rec.x, y_value, head_rec.y));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = MODE_SIGMOID;
		x_valid = 1'b0;
		x_value = '0;
		y_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_modes_under_idling();
		test_output_holdoff();
		test_pause_until_drained();
		wait_drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_400_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/afu_pkg.sv
hdl/afu_div.sv
hdl/activation_function_unit.sv
test/tb.sv
